### rtl/core/slfs_pkg.sv
// shared types and constants for the strided luma frame statistics block
// no dependencies; used by every module under rtl/core
`timescale 1ns / 1ps
`default_nettype none

package slfs_pkg;

  // field and accumulator widths
  localparam int LUMA_W  = 8;
  localparam int SUM_W   = 21;
  localparam int COUNT_W = 14;

  // frame summary queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // parameter defaults
  localparam int DEF_STRIDE          = 32;
  localparam int DEF_MAX_FRAME_BYTES = 262144;

  // per-frame summary handed from the accumulator to the divider
  typedef struct packed {
    logic [SUM_W-1:0]   luma_sum;
    logic [COUNT_W-1:0] sample_count;
    logic [LUMA_W-1:0]  luma_range;
  } stats_t;

endpackage

`default_nettype wire

### rtl/core/slfs_front.sv
// byte accumulator: picks luma samples, keeps sum, count, min and max per frame
// depends on slfs_pkg; pushes one stats_t summary per frame into slfs_queue
`timescale 1ns / 1ps
`default_nettype none

module slfs_front #(
  parameter int STRIDE          = slfs_pkg::DEF_STRIDE,
  parameter int MAX_FRAME_BYTES = slfs_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [slfs_pkg::LUMA_W-1:0] s_tdata,   // [7:0] pixel_byte
  input  wire logic                       s_tlast,   // frame_end
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_data,  // luma_on_even_bytes
  input  wire logic                       q_full,
  output logic                            q_push,
  output slfs_pkg::stats_t                q_push_data
);

  localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
  localparam int PHASE_W = $clog2(STRIDE);

  logic                          luma_on_even_bytes;
  logic [POS_W-1:0]              byte_position;
  logic [PHASE_W-1:0]            phase;
  logic [slfs_pkg::SUM_W-1:0]    luma_sum;
  logic [slfs_pkg::COUNT_W-1:0]  sample_count;
  logic [slfs_pkg::LUMA_W-1:0]   running_minimum;
  logic [slfs_pkg::LUMA_W-1:0]   running_maximum;

  logic                          accept;
  logic                          in_window;
  logic                          is_sample;
  logic [slfs_pkg::SUM_W:0]      sum_wide;
  logic [POS_W-1:0]              byte_position_next;
  logic [PHASE_W-1:0]            phase_next;
  logic [slfs_pkg::SUM_W-1:0]    luma_sum_next;
  logic [slfs_pkg::COUNT_W-1:0]  sample_count_next;
  logic [slfs_pkg::LUMA_W-1:0]   running_minimum_next;
  logic [slfs_pkg::LUMA_W-1:0]   running_maximum_next;

  // handshake: hold off every byte while the frame summary queue is full
  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  // sample selection: phase tracks position modulo the stride
  assign in_window = byte_position < POS_W'(MAX_FRAME_BYTES);
  assign is_sample = in_window &&
                     (luma_on_even_bytes ? (phase == '0) : (phase == PHASE_W'(1)));

  // position and phase advance, both frozen past the frame limit
  always_comb begin
    byte_position_next = byte_position;
    phase_next         = phase;
    if (in_window) begin
      byte_position_next = byte_position + POS_W'(1);
      phase_next = (phase == PHASE_W'(STRIDE - 1)) ? '0 : phase + PHASE_W'(1);
    end
  end

  // saturating accumulators and running extremes
  assign sum_wide = {1'b0, luma_sum} + (slfs_pkg::SUM_W + 1)'(s_tdata);

  always_comb begin
    luma_sum_next        = luma_sum;
    sample_count_next    = sample_count;
    running_minimum_next = running_minimum;
    running_maximum_next = running_maximum;
    if (is_sample) begin
      luma_sum_next = sum_wide[slfs_pkg::SUM_W] ? '1 : sum_wide[slfs_pkg::SUM_W-1:0];
      if (sample_count != '1) begin
        sample_count_next = sample_count + slfs_pkg::COUNT_W'(1);
      end
      if (s_tdata < running_minimum) begin
        running_minimum_next = s_tdata;
      end
      if (s_tdata > running_maximum) begin
        running_maximum_next = s_tdata;
      end
    end
  end

  // frame summary, including the last byte itself
  assign q_push                   = accept && s_tlast;
  assign q_push_data.luma_sum     = luma_sum_next;
  assign q_push_data.sample_count = sample_count_next;
  assign q_push_data.luma_range   = running_maximum_next - running_minimum_next;

  // mode register and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_on_even_bytes <= 1'b1;
      byte_position      <= '0;
      phase              <= '0;
      luma_sum           <= '0;
      sample_count       <= '0;
      running_minimum    <= '1;
      running_maximum    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        luma_on_even_bytes <= cfg_data;
      end
      if (accept) begin
        if (s_tlast) begin
          byte_position   <= '0;
          phase           <= '0;
          luma_sum        <= '0;
          sample_count    <= '0;
          running_minimum <= '1;
          running_maximum <= '0;
        end else begin
          byte_position   <= byte_position_next;
          phase           <= phase_next;
          luma_sum        <= luma_sum_next;
          sample_count    <= sample_count_next;
          running_minimum <= running_minimum_next;
          running_maximum <= running_maximum_next;
        end
      end
    end
  end

  // checks
  a_phase_tracks_position: assert property (@(posedge clk) disable iff (rst)
    (byte_position < POS_W'(STRIDE)) |-> (POS_W'(phase) == byte_position))
    else $error("phase out of step with byte position");

  a_clear_after_frame: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (sample_count == '0 && byte_position == '0 && luma_sum == '0))
    else $error("frame state not cleared after frame end");

endmodule

`default_nettype wire

### rtl/core/slfs_queue.sv
// short queue of frame summaries between the accumulator and the divider
// depends on slfs_pkg for stats_t and the queue depth
`timescale 1ns / 1ps
`default_nettype none

module slfs_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  slfs_pkg::stats_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            pop_valid,
  output slfs_pkg::stats_t pop_data
);

  localparam int DEPTH  = slfs_pkg::QUEUE_DEPTH;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  slfs_pkg::stats_t   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full      = (fill == FILL_W'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // checks
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("frame summary pushed into a full queue");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill level beyond depth");

endmodule

`default_nettype wire

### rtl/core/slfs_back.sv
// per-frame result unit: bit-serial mean division and registered result output
// depends on slfs_pkg; pops stats_t entries from slfs_queue
`timescale 1ns / 1ps
`default_nettype none

module slfs_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  slfs_pkg::stats_t                   q_data,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [2*slfs_pkg::LUMA_W-1:0]      m_tdata   // [7:0] mean_luma, [15:8] luma_range
);

  localparam int STEP_W = $clog2(slfs_pkg::SUM_W);

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    HOLD
  } state_t;

  state_t                        state;
  logic [slfs_pkg::SUM_W-1:0]    quot;
  logic [slfs_pkg::COUNT_W-1:0]  rem;
  logic [slfs_pkg::COUNT_W-1:0]  divisor;
  logic [slfs_pkg::LUMA_W-1:0]   luma_range;
  logic [STEP_W-1:0]             step;

  logic [slfs_pkg::COUNT_W:0]    trial;
  logic                          fits;
  logic [slfs_pkg::COUNT_W:0]    trial_diff;
  logic [slfs_pkg::LUMA_W-1:0]   mean_luma;
  logic                          load_result;

  assign q_pop = (state == IDLE) && q_valid;

  // one restoring division step per cycle
  assign trial      = {rem, quot[slfs_pkg::SUM_W-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  // quotient clamped to one byte
  assign mean_luma = (|quot[slfs_pkg::SUM_W-1:slfs_pkg::LUMA_W]) ? '1
                                                             : quot[slfs_pkg::LUMA_W-1:0];

  // finished result moves into a free or draining output register
  assign load_result = (state == HOLD) && (!m_tvalid || m_tready);

  // sequencer, divider registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      step     <= '0;
    end else begin
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            divisor <= q_data.sample_count;
            rem     <= '0;
            step    <= '0;
            if (q_data.sample_count == '0) begin
              quot       <= '0;
              luma_range <= '0;
              state      <= HOLD;
            end else begin
              quot       <= q_data.luma_sum;
              luma_range <= q_data.luma_range;
              state      <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          rem  <= fits ? trial_diff[slfs_pkg::COUNT_W-1:0] : trial[slfs_pkg::COUNT_W-1:0];
          quot <= {quot[slfs_pkg::SUM_W-2:0], fits};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(slfs_pkg::SUM_W - 1)) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (load_result) begin
            m_tdata <= {luma_range, mean_luma};
            state   <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // checks
  a_remainder_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == DIVIDE) |-> (rem < divisor))
    else $error("division remainder not below divisor");

  a_result_after_hold: assert property (@(posedge clk) disable iff (rst)
    (state == HOLD && (!m_tvalid || m_tready)) |=> (m_tvalid && state == IDLE))
    else $error("finished result not loaded into output register");

endmodule

`default_nettype wire

### rtl/core/strided_luma_frame_stats.sv
// top level of the strided luma frame statistics block
// depends on slfs_pkg, slfs_front, slfs_queue and slfs_back
// throughput: one frame byte per cycle; input stalls only while two frame summaries wait
// result path: the last byte's summary passes the queue, the bit-serial divider and the output register
// a frame with no sampled byte skips the divider and gives a zero mean and range
// reset: synchronous, clears frame state and queue, mode returns to luma on even bytes
`timescale 1ns / 1ps
`default_nettype none

module strided_luma_frame_stats #(
  parameter int STRIDE          = slfs_pkg::DEF_STRIDE,
  parameter int MAX_FRAME_BYTES = slfs_pkg::DEF_MAX_FRAME_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [slfs_pkg::LUMA_W-1:0]    s_tdata,   // [7:0] pixel_byte
  input  wire logic                           s_tlast,   // frame_end
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [2*slfs_pkg::LUMA_W-1:0]       m_tdata,   // [7:0] mean_luma, [15:8] luma_range
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_data   // luma_on_even_bytes
);

  logic             q_full;
  logic             q_push;
  slfs_pkg::stats_t q_push_data;
  logic             q_pop;
  logic             q_valid;
  slfs_pkg::stats_t q_data;

  // byte accumulator
  slfs_front #(
    .STRIDE          (STRIDE),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // frame summary queue
  slfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // divider and result register
  slfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

### test/luma_stats_checker.sv
// checker for the strided luma frame statistics block: watches the byte, result and mode channels
// predicts each frame's mean and range and compares; depends on slfs_pkg
`timescale 1ns / 1ps

module luma_stats_checker #(
  parameter int STRIDE          = slfs_pkg::DEF_STRIDE,
  parameter int MAX_FRAME_BYTES = slfs_pkg::DEF_MAX_FRAME_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [slfs_pkg::LUMA_W-1:0]     s_tdata,   // [7:0] pixel_byte
  input  logic                            s_tlast,   // frame_end
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [2*slfs_pkg::LUMA_W-1:0]   m_tdata,   // [7:0] mean_luma, [15:8] luma_range
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic                            cfg_data,  // luma_on_even_bytes
  output int                              fail_count,
  output int                              pending,
  output int                              frames_checked
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES) + 1;
  localparam logic [slfs_pkg::SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [slfs_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [slfs_pkg::LUMA_W-1:0]  LUMA_MAX  = '1;

  typedef struct packed {
    logic [slfs_pkg::LUMA_W-1:0] mean_luma;
    logic [slfs_pkg::LUMA_W-1:0] luma_range;
  } frame_stats_t;

  // predicted frame state
  logic                          even_mode;
  logic [POS_W-1:0]              frame_pos;
  logic [slfs_pkg::SUM_W-1:0]    sum_acc;
  logic [slfs_pkg::COUNT_W-1:0]  count_acc;
  logic [slfs_pkg::LUMA_W-1:0]   min_acc;
  logic [slfs_pkg::LUMA_W-1:0]   max_acc;

  frame_stats_t expected_stats[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic clear_frame_state();
    frame_pos = '0;
    sum_acc   = '0;
    count_acc = '0;
    min_acc   = LUMA_MAX;
    max_acc   = '0;
  endtask

  // fold one accepted byte into the frame state, close the frame on its last byte
  task automatic accumulate_byte(input logic [slfs_pkg::LUMA_W-1:0] pix, input logic last);
    logic [POS_W-1:0]             first_pos;
    logic [slfs_pkg::SUM_W:0]     wide_sum;
    logic [slfs_pkg::SUM_W-1:0]   quotient;
    frame_stats_t                 stats;
    first_pos = even_mode ? '0 : POS_W'(1);
    if (frame_pos < POS_W'(MAX_FRAME_BYTES)) begin
      if (frame_pos >= first_pos && (int'(frame_pos - first_pos) % STRIDE) == 0) begin
        wide_sum = {1'b0, sum_acc} + (slfs_pkg::SUM_W + 1)'(pix);
        sum_acc = wide_sum[slfs_pkg::SUM_W] ? SUM_MAX : wide_sum[slfs_pkg::SUM_W-1:0];
        if (count_acc != COUNT_MAX) count_acc = count_acc + slfs_pkg::COUNT_W'(1);
        if (pix < min_acc) min_acc = pix;
        if (pix > max_acc) max_acc = pix;
      end
      frame_pos = frame_pos + POS_W'(1);
    end
    if (last) begin
      if (count_acc == '0) begin
        stats = '0;
      end else begin
        quotient = sum_acc / slfs_pkg::SUM_W'(count_acc);
        stats.mean_luma  = (|quotient[slfs_pkg::SUM_W-1:slfs_pkg::LUMA_W]) ? LUMA_MAX
                                                              : quotient[slfs_pkg::LUMA_W-1:0];
        stats.luma_range = max_acc - min_acc;
      end
      expected_stats.push_back(stats);
      pending++;
      clear_frame_state();
    end
  endtask

  initial begin
    fail_count     = 0;
    pending        = 0;
    frames_checked = 0;
    even_mode      = 1'b1;
    clear_frame_state();
  end

  always @(posedge clk) begin
    frame_stats_t want;
    if (rst) begin
      even_mode = 1'b1;
      clear_frame_state();
      expected_stats.delete();
      pending = 0;
    end else begin
      // result transaction against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("result with nothing expected, mean", m_tdata[7:0], 0);
        end else begin
          want = expected_stats.pop_front();
          pending--;
          frames_checked++;
          if (m_tdata[7:0] !== want.mean_luma)
            report_mismatch("mean_luma", m_tdata[7:0], want.mean_luma);
          if (m_tdata[15:8] !== want.luma_range)
            report_mismatch("luma_range", m_tdata[15:8], want.luma_range);
        end
      end
      // mode write
      if (cfg_valid && cfg_ready) even_mode = cfg_data;
      // byte transaction
      if (s_tvalid && s_tready) accumulate_byte(s_tdata, s_tlast);
    end
  end

endmodule

### test/testbench.sv
// top of the strided luma frame statistics test: clock, reset, byte and mode stimulus, verdict
// depends on slfs_pkg, strided_luma_frame_stats and luma_stats_checker
`timescale 1ns / 1ps

module testbench;

  localparam int STRIDE           = slfs_pkg::DEF_STRIDE;
  localparam int MAX_FRAME_BYTES  = slfs_pkg::DEF_MAX_FRAME_BYTES;
  localparam int RANDOM_ITEMS     = 1100;
  localparam int MIN_FRAMES       = 20;
  localparam int SETTLE_CYCLES    = 30;
  localparam int TAIL_CYCLES      = 40;
  localparam int LONG_EXTRA       = 37;
  localparam int LONG_FRAME_BYTES = 8 * STRIDE + LONG_EXTRA;
  localparam int CYCLE_LIMIT      = 3000000;
  localparam logic MODE_YUYV      = 1'b1;
  localparam logic MODE_UYVY      = 1'b0;

  typedef enum int {RX_ALWAYS, RX_THREE_OF_FIVE, RX_SIX_OF_SEVEN, RX_BURSTY} rx_pattern_e;
  typedef enum int {PIX_UNIFORM, PIX_EXTREMES, PIX_NARROW, PIX_CONSTANT} pix_style_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  int fail_count;
  int pending;
  int frames_checked;

  int cycle_count  = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int mode_writes  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;

  // clock
  always #4 clk = ~clk;

  strided_luma_frame_stats #(
    .STRIDE          (STRIDE),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  luma_stats_checker #(
    .STRIDE          (STRIDE),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side back-pressure in one of four patterns, picked anew at random over the run
  rx_pattern_e rx_mode = RX_ALWAYS;
  int          rx_cycle = 0;
  int          rx_stall = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_pattern_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:        m_tready <= 1'b1;
      RX_THREE_OF_FIVE: m_tready <= (rx_cycle % 5) < 3;
      RX_SIX_OF_SEVEN:  m_tready <= (rx_cycle % 7) != 0;
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall = $urandom_range(1, 40);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // one byte transaction, called and returning at a falling edge; bursts with random gaps when gaps_on is set
  task automatic send_byte(input logic [7:0] pix, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) frames_sent++;
  endtask

  // let every expected result drain, then give the divider time to go quiet
  task automatic wait_for_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // frame of random content, sometimes with a mode change part way through
  task automatic send_frame(input int len);
    pix_style_e  style;
    logic [7:0]  base;
    logic [7:0]  pix;
    int          switch_at;
    style = pix_style_e'($urandom_range(0, 3));
    base = 8'($urandom_range(0, 255));
    switch_at = (len > 40 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
    for (int i = 0; i < len; i++) begin
      if (switch_at != 0 && i == switch_at) begin
        wait_for_idle();
        write_mode(1'($urandom_range(0, 1)));
      end
      case (style)
        PIX_UNIFORM:  pix = 8'($urandom_range(0, 255));
        PIX_EXTREMES: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_NARROW:   pix = base ^ 8'($urandom_range(0, 7));
        default:      pix = base;
      endcase
      send_byte(pix, i == len - 1);
    end
  endtask

  initial begin
    int         len;
    int         nframes;
    int         pick;
    int         random_start;
    logic [7:0] pix;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = MODE_YUYV;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single-byte frames at both extremes and a two-byte frame, luma on even bytes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // luma on odd bytes: a one-byte frame has no sample
    wait_for_idle();
    write_mode(MODE_UYVY);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'hED, 1'b1);
    // mode change inside a frame, odd to even
    send_byte(8'h01, 1'b0);
    send_byte(8'h28, 1'b0);
    wait_for_idle();
    write_mode(MODE_YUYV);
    send_byte(8'h02, 1'b1);
    // mode change inside a frame, even to odd
    send_byte(8'h0A, 1'b0);
    wait_for_idle();
    write_mode(MODE_UYVY);
    send_byte(8'hFA, 1'b1);

    // random phases: mode per phase, a few frames of mixed length
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_ITEMS || frames_sent < MIN_FRAMES) begin
      wait_for_idle();
      write_mode(1'($urandom_range(0, 1)));
      gaps_on = $urandom_range(0, 3) != 0;
      nframes = $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)      len = $urandom_range(1, 8);
        else if (pick < 8) len = $urandom_range(9, 70);
        else               len = $urandom_range(71, 200);
        send_frame(len);
      end
    end

    // one long frame over several strides: bright samples with a single dark one
    wait_for_idle();
    write_mode(MODE_YUYV);
    gaps_on = 1'b0;
    for (int p = 0; p < LONG_FRAME_BYTES; p++) begin
      if (p % STRIDE != 0)       pix = 8'($urandom_range(0, 255));
      else if (p == 5 * STRIDE)  pix = 8'h03;
      else                       pix = 8'hFF;
      send_byte(pix, p == LONG_FRAME_BYTES - 1);
    end

    // drain and check for stray results
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d bytes in %0d frames over %0d mode writes, both luma phases",
             bytes_sent, frames_sent, mode_writes);
    $display("checked %0d frame results in %0d cycles, including one long multi-stride frame",
             frames_checked, cycle_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/slfs_pkg.sv
rtl/core/slfs_front.sv
rtl/core/slfs_queue.sv
rtl/core/slfs_back.sv
rtl/core/strided_luma_frame_stats.sv
test/luma_stats_checker.sv
test/testbench.sv
